>>> src/force_gesture_mode_controller_core_macros.svh
// assertion macros shared by the rtl
`ifndef FORCE_GESTURE_MODE_CONTROLLER_CORE_MACROS_SVH
`define FORCE_GESTURE_MODE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication
`define FGMC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("fgmc implication check failed");

// next-cycle implication
`define FGMC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("fgmc next-cycle check failed");

`endif

>>> src/fgmc_pkg.sv
package fgmc_pkg;

	localparam int CFG_W      = 15;
	localparam int THR_SQ_W   = 2 * CFG_W;
	localparam int CFG_IDX_W  = 3;
	localparam int MODE_W     = 3;
	localparam int FTYPE_W    = 5;

	localparam logic [CFG_IDX_W-1:0] REG_LIN_PEAK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_PEAK  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIN_CLASS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_CLASS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TAKEOFF   = 3'd4;

	localparam logic [CFG_W-1:0] LIN_PEAK_RST  = 15'd256;
	localparam logic [CFG_W-1:0] ROT_PEAK_RST  = 15'd256;
	localparam logic [CFG_W-1:0] LIN_CLASS_RST = 15'd128;
	localparam logic [CFG_W-1:0] ROT_CLASS_RST = 15'd128;

	localparam logic [MODE_W-1:0] M_HOVER   = 3'd0;
	localparam logic [MODE_W-1:0] M_FLOAT   = 3'd1;
	localparam logic [MODE_W-1:0] M_PASSIVE = 3'd2;
	localparam logic [MODE_W-1:0] M_ANIM    = 3'd3;
	localparam logic [MODE_W-1:0] M_TAKEOFF = 3'd4;
	localparam logic [MODE_W-1:0] M_LAND    = 3'd5;
	localparam logic [MODE_W-1:0] M_MOVE    = 3'd6;

	localparam logic [FTYPE_W-1:0] FT_NONE   = 5'd0;
	localparam logic [FTYPE_W-1:0] FT_ECC    = 5'd1;
	localparam logic [FTYPE_W-1:0] FT_TW_CCW = 5'd2;
	localparam logic [FTYPE_W-1:0] FT_TW_CW  = 5'd3;
	localparam logic [FTYPE_W-1:0] FT_FRONT  = 5'd4;
	localparam logic [FTYPE_W-1:0] FT_BACK   = 5'd5;
	localparam logic [FTYPE_W-1:0] FT_LEFT   = 5'd6;
	localparam logic [FTYPE_W-1:0] FT_RIGHT  = 5'd7;
	localparam logic [FTYPE_W-1:0] FT_L_UP   = 5'd8;
	localparam logic [FTYPE_W-1:0] FT_R_UP   = 5'd9;
	localparam logic [FTYPE_W-1:0] FT_B_UP   = 5'd10;
	localparam logic [FTYPE_W-1:0] FT_F_UP   = 5'd11;
	localparam logic [FTYPE_W-1:0] FT_L_DN   = 5'd12;
	localparam logic [FTYPE_W-1:0] FT_R_DN   = 5'd13;
	localparam logic [FTYPE_W-1:0] FT_B_DN   = 5'd14;
	localparam logic [FTYPE_W-1:0] FT_F_DN   = 5'd15;
	localparam logic [FTYPE_W-1:0] FT_BOTTOM = 5'd16;
	localparam logic [FTYPE_W-1:0] FT_TOP    = 5'd17;

	typedef struct packed {
		logic locked;
		logic pdone;
	} fgmc_flags_t;

	typedef struct packed {
		logic [THR_SQ_W-1:0] lin_peak_sq;
		logic [THR_SQ_W-1:0] rot_peak_sq;
		logic [CFG_W-1:0]    lin_class;
		logic [CFG_W-1:0]    rot_class;
		logic                allow_takeoff;
	} fgmc_cfg_t;

endpackage

>>> src/fgmc_front.sv
module fgmc_front import fgmc_pkg::*; #(
	parameter int SW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [5:0][SW-1:0]   in_sample,
	input  fgmc_flags_t          in_flags,
	input  logic                 full,
	output logic                 push,
	output logic [5:0][SW-1:0]   sample,
	output logic [2*SW-1:0]      sq_lin,
	output logic [2*SW-1:0]      sq_ang,
	output fgmc_flags_t          flags
);

	localparam int SQW = 2 * SW;

	logic                valid_s1;
	logic [5:0][SW-1:0]  sample_s1;
	fgmc_flags_t         flags_s1;
	logic signed [SQW-1:0] prod [6];
	logic                accept;

	assign push     = valid_s1 && !full;
	assign in_stall = valid_s1 && full;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= in_sample;
			flags_s1  <= in_flags;
		end
	end

	// squared axis forces, always non-negative
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			prod[i] = SQW'($signed(sample_s1[i])) * SQW'($signed(sample_s1[i]));
		end
	end

	assign sq_lin = $unsigned(prod[0]) + $unsigned(prod[1]) + $unsigned(prod[2]);
	assign sq_ang = $unsigned(prod[3]) + $unsigned(prod[4]) + $unsigned(prod[5]);
	assign sample = sample_s1;
	assign flags  = flags_s1;

endmodule

>>> src/fgmc_fifo.sv
`include "force_gesture_mode_controller_core_macros.svh"

module fgmc_fifo import fgmc_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	`FGMC_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`FGMC_ASSERT_IMP(a_no_pop_empty, clk, arst_n, count_q == '0, !pop)
	`FGMC_ASSERT_NXT(a_push_grows, clk, arst_n, push && !pop, count_q == $past(count_q) + CW'(1))

endmodule

>>> src/fgmc_back.sv
`include "force_gesture_mode_controller_core_macros.svh"

module fgmc_back import fgmc_pkg::*; #(
	parameter int SW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fgmc_cfg_t            cfg,
	input  logic                 head_valid,
	input  logic [5:0][SW-1:0]   sample,
	input  logic [2*SW-1:0]      sq_lin,
	input  logic [2*SW-1:0]      sq_ang,
	input  fgmc_flags_t          flags,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [MODE_W-1:0]    mode,
	output logic                 mode_changed,
	output logic [FTYPE_W-1:0]   force_type,
	output logic                 peak_seen
);

	localparam int SQW  = 2 * SW;
	localparam int CMPW = (SQW > THR_SQ_W) ? SQW : THR_SQ_W;
	localparam int MW   = (SW > CFG_W) ? SW : CFG_W;

	logic                 out_valid_q;
	logic                 started_q;
	logic [MODE_W-1:0]    mode_q;
	logic [5:0][SW-1:0]   cur_q;
	logic [SQW-1:0]       cl_q;
	logic [SQW-1:0]       ca_q;
	logic                 changed_q;
	logic [FTYPE_W-1:0]   type_q;
	logic                 peak_q;

	logic                 take;
	logic                 above;
	logic                 peak;
	logic [FTYPE_W-1:0]   cls;
	logic [FTYPE_W-1:0]   ftype;
	logic [MODE_W-1:0]    mode_cur;
	logic [MODE_W-1:0]    mode_nxt;
	logic                 copy;

	function automatic logic [MW-1:0] mag(input logic [SW-1:0] v);
		logic [SW-1:0] a;
		a = v[SW-1] ? (~v + SW'(1)) : v;
		return MW'(a);
	endfunction

	function automatic logic pos(input logic [SW-1:0] v);
		return !v[SW-1] && (v != '0);
	endfunction

	function automatic logic [FTYPE_W-1:0] classify(
		input logic [5:0][SW-1:0] f,
		input logic [CFG_W-1:0]   lt,
		input logic [CFG_W-1:0]   rt
	);
		logic [MW-1:0]      lx, ly, lz, ax, ay, az, lte, rte;
		logic               lin_xy;
		logic [FTYPE_W-1:0] r;
		lx = mag(f[0]);
		ly = mag(f[1]);
		lz = mag(f[2]);
		ax = mag(f[3]);
		ay = mag(f[4]);
		az = mag(f[5]);
		lte = MW'(lt);
		rte = MW'(rt);
		lin_xy = (lx > lte) || (ly > lte);
		if (az > rte) begin
			if (lin_xy) r = FT_ECC;
			else r = pos(f[5]) ? FT_TW_CCW : FT_TW_CW;
		end else if (lin_xy) begin
			if (lx > lte) r = f[0][SW-1] ? FT_FRONT : FT_BACK;
			else r = f[1][SW-1] ? FT_LEFT : FT_RIGHT;
		end else if ((ax > rte) || (ay > rte)) begin
			if (pos(f[2])) begin
				if (ax > ay) r = pos(f[3]) ? FT_L_UP : FT_R_UP;
				else r = pos(f[4]) ? FT_B_UP : FT_F_UP;
			end else begin
				if (ax > ay) r = pos(f[3]) ? FT_L_DN : FT_R_DN;
				else r = pos(f[4]) ? FT_B_DN : FT_F_DN;
			end
		end else if (lz > lte) begin
			r = pos(f[2]) ? FT_BOTTOM : FT_TOP;
		end else begin
			r = FT_NONE;
		end
		return r;
	endfunction

	assign take = head_valid && (!out_valid_q || !out_stall);
	assign pop  = take;

	assign above = (CMPW'(sq_lin) > CMPW'(cfg.lin_peak_sq)) ||
		(CMPW'(sq_ang) > CMPW'(cfg.rot_peak_sq));
	assign peak  = above && ((sq_lin < cl_q) || (sq_ang < ca_q));
	assign cls   = classify(cur_q, cfg.lin_class, cfg.rot_class);
	assign ftype = peak ? cls : FT_NONE;

	assign mode_cur = started_q ? mode_q : (cfg.allow_takeoff ? M_LAND : M_FLOAT);

	always_comb begin
		mode_nxt = mode_cur;
		copy     = 1'b0;
		if (!flags.locked) begin
			case (mode_cur)
				M_HOVER: begin
					if (peak) begin
						if (ftype == FT_TOP) begin
							mode_nxt = M_LAND;
						end else begin
							copy     = 1'b1;
							mode_nxt = M_ANIM;
						end
					end
				end
				M_FLOAT: begin
					if (peak) begin
						if (ftype == FT_TOP) begin
							mode_nxt = M_LAND;
						end else if (ftype == FT_L_DN || ftype == FT_R_DN ||
								ftype == FT_F_DN || ftype == FT_B_DN) begin
							mode_nxt = M_PASSIVE;
						end else if (ftype == FT_FRONT || ftype == FT_BACK ||
								ftype == FT_LEFT || ftype == FT_RIGHT) begin
							mode_nxt = M_MOVE;
						end
					end
				end
				M_PASSIVE: mode_nxt = flags.pdone ? M_HOVER : M_FLOAT;
				M_ANIM:    mode_nxt = M_HOVER;
				M_TAKEOFF: mode_nxt = M_HOVER;
				M_LAND: begin
					if (peak && ftype == FT_F_UP && cfg.allow_takeoff) begin
						mode_nxt = M_TAKEOFF;
					end
				end
				M_MOVE:    mode_nxt = M_FLOAT;
				default:   mode_nxt = mode_cur;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
			mode_q      <= M_FLOAT;
			cur_q       <= '0;
			cl_q        <= '0;
			ca_q        <= '0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				started_q <= 1'b1;
				mode_q    <= mode_nxt;
				// hover to animation keeps the older sample as current
				if (!copy) begin
					cur_q <= sample;
					cl_q  <= sq_lin;
					ca_q  <= sq_ang;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			changed_q <= (mode_nxt != mode_cur);
			type_q    <= ftype;
			peak_q    <= peak;
		end
	end

	assign out_valid    = out_valid_q;
	assign mode         = mode_q;
	assign mode_changed = changed_q;
	assign force_type   = type_q;
	assign peak_seen    = peak_q;

	`FGMC_ASSERT_IMP(a_type_needs_peak, clk, arst_n, out_valid_q && !peak_q, type_q == FT_NONE)
	`FGMC_ASSERT_IMP(a_mode_range, clk, arst_n, 1'b1, mode_q <= M_MOVE)
	`FGMC_ASSERT_NXT(a_locked_holds, clk, arst_n, take && flags.locked && started_q, !changed_q)

endmodule

>>> src/force_gesture_mode_controller_core.sv
// channel   direction  handshake            payload
// in        sink       in_valid / in_stall  lin_x..ang_z, state_locked, passive_done
// out       source     out_valid/out_stall  mode, mode_changed, force_type, peak_seen
// cfg       sink       cfg_we               cfg_index, cfg_wdata
//
// one beat per cycle sustained while out_stall is low; beats pass the input stage, queue and output register
// front stage squares the six axes, back stage compares, classifies and steps the mode
// asynchronous reset, no clearing pass; the first beat after reset picks land or float
// out_stall backs up into the QUEUE_DEPTH entry queue; in_stall rises only once it is full
module force_gesture_mode_controller_core import fgmc_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int QUEUE_DEPTH  = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [CFG_W-1:0]               cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] lin_x,
	input  logic signed [SAMPLE_WIDTH-1:0] lin_y,
	input  logic signed [SAMPLE_WIDTH-1:0] lin_z,
	input  logic signed [SAMPLE_WIDTH-1:0] ang_x,
	input  logic signed [SAMPLE_WIDTH-1:0] ang_y,
	input  logic signed [SAMPLE_WIDTH-1:0] ang_z,
	input  logic                           state_locked,
	input  logic                           passive_done,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [MODE_W-1:0]              mode,
	output logic                           mode_changed,
	output logic [FTYPE_W-1:0]             force_type,
	output logic                           peak_seen
);

	localparam int SW  = SAMPLE_WIDTH;
	localparam int SQW = 2 * SW;
	localparam int EW  = 6 * SW + 2 * SQW + $bits(fgmc_flags_t);

	fgmc_cfg_t           cfg_q;
	logic [5:0][SW-1:0]  in_sample;
	fgmc_flags_t         in_flags;

	logic                f_push;
	logic [5:0][SW-1:0]  f_sample;
	logic [SQW-1:0]      f_sq_lin;
	logic [SQW-1:0]      f_sq_ang;
	fgmc_flags_t         f_flags;

	logic                q_full;
	logic                q_not_empty;
	logic [EW-1:0]       q_rdata;
	logic                b_pop;
	logic [5:0][SW-1:0]  b_sample;
	logic [SQW-1:0]      b_sq_lin;
	logic [SQW-1:0]      b_sq_ang;
	fgmc_flags_t         b_flags;

	// peak thresholds kept squared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lin_peak_sq   <= THR_SQ_W'(LIN_PEAK_RST) * THR_SQ_W'(LIN_PEAK_RST);
			cfg_q.rot_peak_sq   <= THR_SQ_W'(ROT_PEAK_RST) * THR_SQ_W'(ROT_PEAK_RST);
			cfg_q.lin_class     <= LIN_CLASS_RST;
			cfg_q.rot_class     <= ROT_CLASS_RST;
			cfg_q.allow_takeoff <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LIN_PEAK:  cfg_q.lin_peak_sq <= THR_SQ_W'(cfg_wdata) * THR_SQ_W'(cfg_wdata);
				REG_ROT_PEAK:  cfg_q.rot_peak_sq <= THR_SQ_W'(cfg_wdata) * THR_SQ_W'(cfg_wdata);
				REG_LIN_CLASS: cfg_q.lin_class <= cfg_wdata;
				REG_ROT_CLASS: cfg_q.rot_class <= cfg_wdata;
				REG_TAKEOFF:   cfg_q.allow_takeoff <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign in_sample = {ang_z, ang_y, ang_x, lin_z, lin_y, lin_x};
	assign in_flags  = '{locked: state_locked, pdone: passive_done};

	fgmc_front #(
		.SW(SW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_sample (in_sample),
		.in_flags  (in_flags),
		.full      (q_full),
		.push      (f_push),
		.sample    (f_sample),
		.sq_lin    (f_sq_lin),
		.sq_ang    (f_sq_ang),
		.flags     (f_flags)
	);

	fgmc_fifo #(
		.W     (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.wdata     ({f_sample, f_sq_lin, f_sq_ang, f_flags}),
		.pop       (b_pop),
		.rdata     (q_rdata),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	assign {b_sample, b_sq_lin, b_sq_ang, b_flags} = q_rdata;

	fgmc_back #(
		.SW(SW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head_valid   (q_not_empty),
		.sample       (b_sample),
		.sq_lin       (b_sq_lin),
		.sq_ang       (b_sq_ang),
		.flags        (b_flags),
		.pop          (b_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mode         (mode),
		.mode_changed (mode_changed),
		.force_type   (force_type),
		.peak_seen    (peak_seen)
	);

endmodule
